>>> sv/vpa_pkg.sv
// Shared types and constants for the variable partition allocator.
// No dependencies; imported by vpa_ram users and the top level.
package vpa_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int TOTAL_UNITS = 1024;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = CW + 1;

    typedef enum logic [1:0] {
        CMD_FIRST = 2'd0,
        CMD_BEST  = 2'd1,
        CMD_WORST = 2'd2,
        CMD_FREE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NOFIT    = 2'd1,
        STS_FULL     = 2'd2,
        STS_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] id;
        logic [9:0]  start;
        logic [10:0] size;
        logic        used;
    } t_entry;

    typedef enum logic [8:0] {
        ST_INIT   = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_SCAN   = 9'b000000100,
        ST_DECIDE = 9'b000001000,
        ST_UP     = 9'b000010000,
        ST_SPLIT  = 9'b000100000,
        ST_FNEXT  = 9'b001000000,
        ST_DOWN   = 9'b010000000,
        ST_DONE   = 9'b100000000
    } t_state;

endpackage

>>> sv/variable_partition_allocator_top.sv
// Variable partition allocator: ordered region table in one RAM.
// Each command scans the region table entry by entry before its result beat; a split
// also shifts the table entries above the chosen one up by one place.
// One command at a time; a waiting result beat stalls the input, and the single
// RAM read port (one entry a cycle) sets the rate.
// Reset: synchronous; the first cycle after reset writes the initial free region.
module variable_partition_allocator_top
    import vpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [10:0] i_request_size,
    input  logic [15:0] i_free_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_granted_id,
    output logic [9:0]  o_granted_start
);

    t_state      r_state;
    logic [CW-1:0] r_count;
    logic [15:0] r_idc;
    t_cmd        r_cmd;
    logic [10:0] r_req;
    logic [15:0] r_fid;
    logic [AW-1:0] r_idx;
    logic        r_have;
    logic [AW-1:0] r_pick;
    logic [10:0] r_psize;
    logic [9:0]  r_pstart;
    t_entry      r_prev;
    t_entry      r_cur;
    logic [XW-1:0] r_j;
    logic [1:0]  r_k;
    t_status     r_ost;
    logic [15:0] r_oid;
    logic [9:0]  r_ostart;
    logic        r_ov;

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    t_entry        wdata;
    t_entry        q;

    vpa_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (q)
    );

    logic          accept;
    logic          scan_last;
    logic          fits;
    logic          better;
    logic          match;
    logic          split;
    logic          nxt_free;
    logic          prv_free;
    logic [XW-1:0] fi_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] pick_x;
    logic [XW-1:0] src;

    assign accept    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE) || r_ov;
    assign cnt_x     = XW'(r_count);
    assign fi_x      = XW'(r_idx);
    assign pick_x    = XW'(r_pick);
    assign scan_last = (fi_x + XW'(1) >= cnt_x);
    assign fits      = !q.used && (q.size >= r_req);
    assign better    = (r_cmd == CMD_BEST && q.size < r_psize) ||
                       (r_cmd == CMD_WORST && q.size > r_psize);
    assign match     = q.used && (q.id == r_fid);
    assign split     = r_psize > r_req;
    assign nxt_free  = (fi_x + XW'(1) < cnt_x) && !q.used;
    assign prv_free  = (r_idx != '0) && !r_prev.used;
    assign src       = (nxt_free) ? fi_x + XW'(2) : fi_x + XW'(1);

    // RAM port control
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = AW'(r_idx + AW'(1));
        case (r_state)
            ST_INIT: begin
                we    = 1'b1;
                wdata = '{id: 16'd1, start: 10'd0, size: 11'(TOTAL_UNITS), used: 1'b0};
            end
            ST_IDLE: begin
                raddr = '0;
            end
            ST_DECIDE: begin
                raddr = AW'(cnt_x - XW'(1));
                if (r_have && !(split && r_count >= CW'(MAX_ENTRIES))) begin
                    we    = 1'b1;
                    waddr = r_pick;
                    wdata = '{id: r_idc, start: r_pstart, size: r_req, used: 1'b1};
                end
            end
            ST_UP: begin
                we    = 1'b1;
                waddr = AW'(r_j + XW'(1));
                wdata = q;
                raddr = AW'(r_j - XW'(1));
            end
            ST_SPLIT: begin
                we    = 1'b1;
                waddr = AW'(pick_x + XW'(1));
                wdata = '{id: r_idc, start: 10'(r_pstart + r_req[9:0]),
                          size: 11'(r_psize - r_req), used: 1'b0};
            end
            ST_FNEXT: begin
                we    = 1'b1;
                raddr = AW'(src);
                if (prv_free) begin
                    waddr = AW'(fi_x - XW'(1));
                    wdata = r_prev;
                    wdata.size = nxt_free ? 11'(r_prev.size + r_cur.size + q.size)
                                          : 11'(r_prev.size + r_cur.size);
                end else begin
                    waddr = r_idx;
                    wdata = r_cur;
                    wdata.used = 1'b0;
                    if (nxt_free) begin
                        wdata.size = 11'(r_cur.size + q.size);
                    end
                end
            end
            ST_DOWN: begin
                we    = 1'b1;
                waddr = AW'(r_j - XW'(r_k));
                wdata = q;
                raddr = AW'(r_j + XW'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_count <= CW'(1);
            r_idc   <= 16'd2;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_INIT: begin
                    r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd   <= t_cmd'(i_command);
                        r_req   <= i_request_size;
                        r_fid   <= i_free_id;
                        r_idx   <= '0;
                        r_have  <= 1'b0;
                        r_psize <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_cmd == CMD_FREE) begin
                        if (match) begin
                            // hold the index on the matching entry
                            r_cur   <= q;
                            r_state <= ST_FNEXT;
                        end else begin
                            r_idx  <= AW'(r_idx + AW'(1));
                            r_prev <= q;
                            if (scan_last) begin
                                r_ost    <= STS_NOTFOUND;
                                r_oid    <= '0;
                                r_ostart <= '0;
                                r_state  <= ST_DONE;
                            end
                        end
                    end else begin
                        r_idx <= AW'(r_idx + AW'(1));
                        if (fits && (!r_have || better)) begin
                            r_have   <= 1'b1;
                            r_pick   <= r_idx;
                            r_psize  <= q.size;
                            r_pstart <= q.start;
                        end
                        // first fit stops at the first candidate
                        if (scan_last || (fits && !r_have && r_cmd == CMD_FIRST)) begin
                            r_state <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE: begin
                    r_oid    <= '0;
                    r_ostart <= '0;
                    if (!r_have) begin
                        r_ost   <= STS_NOFIT;
                        r_state <= ST_DONE;
                    end else if (split && r_count >= CW'(MAX_ENTRIES)) begin
                        r_ost   <= STS_FULL;
                        r_state <= ST_DONE;
                    end else begin
                        r_ost    <= STS_OK;
                        r_oid    <= r_idc;
                        r_ostart <= r_pstart;
                        r_idc    <= r_idc + 16'd1;
                        if (!split) begin
                            r_state <= ST_DONE;
                        end else if (pick_x + XW'(1) < cnt_x) begin
                            r_j     <= cnt_x - XW'(1);
                            r_state <= ST_UP;
                        end else begin
                            r_state <= ST_SPLIT;
                        end
                    end
                end
                ST_UP: begin
                    if (r_j > pick_x + XW'(1)) begin
                        r_j <= r_j - XW'(1);
                    end else begin
                        r_state <= ST_SPLIT;
                    end
                end
                ST_SPLIT: begin
                    r_idc   <= r_idc + 16'd1;
                    r_count <= CW'(r_count + CW'(1));
                    r_state <= ST_DONE;
                end
                ST_FNEXT: begin
                    r_ost    <= STS_OK;
                    r_oid    <= '0;
                    r_ostart <= '0;
                    r_k      <= (prv_free && nxt_free) ? 2'd2 :
                                (prv_free || nxt_free) ? 2'd1 : 2'd0;
                    r_j      <= src;
                    if (!prv_free && !nxt_free) begin
                        r_state <= ST_DONE;
                    end else if (src < cnt_x) begin
                        r_state <= ST_DOWN;
                    end else begin
                        r_count <= CW'(cnt_x - ((prv_free && nxt_free) ? XW'(2) : XW'(1)));
                        r_state <= ST_DONE;
                    end
                end
                ST_DOWN: begin
                    if (r_j + XW'(1) < cnt_x) begin
                        r_j <= r_j + XW'(1);
                    end else begin
                        r_count <= CW'(cnt_x - XW'(r_k));
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // the output register is empty here: the input stalls while a beat waits
                    r_ov    <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_ost;
    assign o_granted_id    = r_oid;
    assign o_granted_start = r_ostart;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(MAX_ENTRIES)))
        else $error("table count out of range");

    a_full_only_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_ost == STS_FULL) |-> (r_count == CW'(MAX_ENTRIES)))
        else $error("table full reported below capacity");

    a_split_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UP || r_state == ST_SPLIT) |-> (r_count < CW'(MAX_ENTRIES)))
        else $error("split started with a full table");
`endif

endmodule

>>> sv/vpa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module vpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule
